/* design/tva_pkg.sv */
// Shared constants and types for the total variation accumulator.
package tva_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int PIX_W   = 16;
	localparam int CFG_W   = 11;
	localparam int TOTAL_W = 48;
	localparam int DIFF_W  = PIX_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SQ_W    = PROD_W + 1;
	localparam int ROOT_W  = (SQ_W + 1) / 2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// register indexes (paddr[2])
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_res_t;

endpackage

/* design/tva_ram.sv */
// Generic simple dual-port RAM with registered read.
module tva_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

/* design/tva_sqrt.sv */
// Iterative floor square root, two radicand bits per cycle.
module tva_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [tva_pkg::SQ_W-1:0] radicand,
	output tva_pkg::sqrt_res_t     res
);
	import tva_pkg::*;

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q, rem_next, trial;
	logic [ROOT_W-1:0] root_q;

	assign rem_next = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial    = REM_W'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.root = root_q;
endmodule

/* design/total_variation_accumulator_unit.sv */
// Total variation accumulator: pixels of a frame arrive in raster order, one word each.
// A pixel of the first row is only stored; every later pixel passes through
// two line store reads, square, sum, then the shared bit-pair square root unit.
// On the last pixel the final row is flushed column by column through the same
// steps, then one result word carries the 48-bit total and the
// saturation flag. Result words wait in an output register; input is taken again
// as soon as the flush has handed its result over.
module total_variation_accumulator_unit #(
	parameter int MAX_WIDTH  = tva_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tva_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [47:0] total_variation, [48] saturated, rest zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tva_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic [CFG_W-1:0] fw_q, fh_q;
	logic [CW-1:0] w_eff, col_q, col_inc;
	logic [HW-1:0] h_eff, row_q;
	logic flush_q, sat_q, out_valid_q, out_sat_q;
	logic [TOTAL_W-1:0] total_q, out_total_q;
	logic signed [PIX_W-1:0] pix_q, m_q, up_raw_q, left_q;
	logic [PROD_W-1:0] dx2_q, dy2_q;

	logic col_last, row_last, cfg_wr, accept, out_load;
	logic [AW-1:0] rd_addr;
	logic signed [PIX_W-1:0] prev_rd, older_rd, rt, left, up, down;
	logic signed [DIFF_W-1:0] dx, dy;
	logic ram_we;
	logic [PIX_W-1:0] prev_wdata;
	logic [TOTAL_W:0] sum;
	sqrt_res_t sq_res;

	// effective dimensions: zero reads as one, above maximum clips
	always_comb begin
		if (fw_q == '0)                  w_eff = CW'(1);
		else if (int'(fw_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else                             w_eff = CW'(fw_q);
		if (fh_q == '0)                   h_eff = HW'(1);
		else if (int'(fh_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else                              h_eff = HW'(fh_q);
	end

	assign col_inc  = col_q + 1'b1;
	assign col_last = (col_inc == w_eff);
	assign row_last = (row_q + 1'b1 == h_eff);

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign prdata   = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(fh_q) : 32'(fw_q);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;

	// result word moves into the output register once that register is free
	assign out_load = (state_q == ST_DONE) && !cfg_wr && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_sat_q, out_total_q};

	// line stores: reads in RD/RD2, write-back in MUL or on a first-row pixel, so no overlap on an entry
	always_comb begin
		rd_addr = col_q[AW-1:0];
		if (state_q == ST_RD2 && !col_last) rd_addr = col_inc[AW-1:0];
	end

	assign ram_we     = (state_q == ST_MUL && !flush_q) || (accept && row_q == '0);
	assign prev_wdata = (state_q == ST_MUL) ? pix_q : s_tdata;

	tva_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
		.clk(clk), .wr_en(ram_we), .wr_addr(col_q[AW-1:0]), .wr_data(prev_wdata),
		.rd_addr(rd_addr), .rd_data(prev_rd)
	);

	tva_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
		.clk(clk), .wr_en(ram_we && state_q == ST_MUL), .wr_addr(col_q[AW-1:0]),
		.wr_data(m_q), .rd_addr(rd_addr), .rd_data(older_rd)
	);

	// window taps and differences
	always_comb begin
		rt   = col_last ? m_q : prev_rd;
		left = (col_q == '0) ? m_q : left_q;
		if (flush_q) up = (h_eff != HW'(1)) ? up_raw_q : m_q;
		else         up = (row_q > HW'(1)) ? up_raw_q : m_q;
		down = flush_q ? m_q : pix_q;
		dx   = DIFF_W'(rt) - DIFF_W'(left);
		dy   = DIFF_W'(up) - DIFF_W'(down);
	end

	tva_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_SUM),
		.radicand(SQ_W'(dx2_q) + SQ_W'(dy2_q)), .res(sq_res)
	);

	assign sum = {1'b0, total_q} + (TOTAL_W + 1)'(sq_res.root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fw_q        <= CFG_W'(1024);
			fh_q        <= CFG_W'(1024);
			col_q       <= '0;
			row_q       <= '0;
			flush_q     <= 1'b0;
			total_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)      out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == REG_FRAME_WIDTH) fw_q <= pwdata[CFG_W-1:0];
				else                              fh_q <= pwdata[CFG_W-1:0];
				col_q   <= '0;
				row_q   <= '0;
				total_q <= '0;
				sat_q   <= 1'b0;
				flush_q <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (accept) begin
							if (row_q != '0) begin
								state_q <= ST_RD;
							end else if (!col_last) begin
								col_q <= col_inc;
							end else begin
								col_q <= '0;
								if (row_last) begin
									flush_q <= 1'b1;
									state_q <= ST_RD;
								end else begin
									row_q <= row_q + 1'b1;
								end
							end
						end
					end
					ST_RD:  state_q <= ST_RD2;
					ST_RD2: state_q <= ST_MUL;
					ST_MUL: state_q <= ST_SUM;
					ST_SUM: state_q <= ST_SQRT;
					ST_SQRT: begin
						if (sq_res.done) begin
							if (sum >= (TOTAL_W + 1)'(TOTAL_MAX)) begin
								total_q <= TOTAL_MAX;
								sat_q   <= 1'b1;
							end else begin
								total_q <= sum[TOTAL_W-1:0];
							end
							if (flush_q) begin
								if (col_last) begin
									state_q <= ST_DONE;
								end else begin
									col_q   <= col_inc;
									state_q <= ST_RD;
								end
							end else if (!col_last) begin
								col_q   <= col_inc;
								state_q <= ST_IDLE;
							end else begin
								col_q <= '0;
								if (row_last) begin
									flush_q <= 1'b1;
									state_q <= ST_RD;
								end else begin
									row_q   <= row_q + 1'b1;
									state_q <= ST_IDLE;
								end
							end
						end
					end
					ST_DONE: begin
						if (!out_valid_q || m_tready) begin
							col_q       <= '0;
							row_q       <= '0;
							total_q     <= '0;
							sat_q       <= 1'b0;
							flush_q     <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) pix_q <= s_tdata;
		if (state_q == ST_RD2) begin
			m_q      <= prev_rd;
			up_raw_q <= older_rd;
		end
		if (state_q == ST_MUL) begin
			left_q <= m_q;
			dx2_q  <= PROD_W'($unsigned(PROD_W'(dx) * PROD_W'(dx)));
			dy2_q  <= PROD_W'($unsigned(PROD_W'(dy) * PROD_W'(dy)));
		end
		if (out_load) begin
			out_total_q <= total_q;
			out_sat_q   <= sat_q;
		end
	end

	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[48]) |-> (m_tdata[47:0] == TOTAL_MAX))
		else $error("saturated result without full total");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < w_eff) else $error("column position beyond frame width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < h_eff) else $error("row position beyond frame height");

	a_sqrt_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_res.done |-> (state_q == ST_SQRT)) else $error("root ready outside wait state");
endmodule

/* dv/tb_total_variation_accumulator_unit.sv */
// Testbench for the total variation accumulator: directed table, random frames, scoreboard.
`timescale 1ns / 1ps

module tb_total_variation_accumulator_unit;
	import tva_pkg::*;

	localparam int  MAXW = DEF_MAX_WIDTH;
	localparam int  MAXH = DEF_MAX_HEIGHT;
	localparam int  ITEM_GOAL = 730;
	localparam int  SETTLE = 64;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef enum logic [1:0] {ROW_WIDTH, ROW_HEIGHT, ROW_PIXEL} row_kind_e;
	typedef struct {
		row_kind_e   kind;
		logic [31:0] value;
		bit          typed;
		logic [47:0] total;
	} stim_row_t;
	typedef struct {
		logic [TOTAL_W-1:0] total;
		logic               sat;
	} frame_sum_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] pixel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // [47:0] total_variation, [48] saturated
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	total_variation_accumulator_unit DUT (.*);

	always #10 clk = ~clk;

	// shadow of the block
	logic [15:0]        older_row [MAXW];
	logic [15:0]        prev_row [MAXW];
	int                 win_left, win_mid, win_right;
	int                 col_pos, row_pos;
	logic [TOTAL_W-1:0] tv_total;
	logic               tv_sat;
	logic [10:0]        width_reg = 11'd1024, height_reg = 11'd1024;

	frame_sum_t sum_q [$];
	int  mismatches = 0, results_seen = 0, pixels_sent = 0, frames_done = 0;
	int  idle_mode = 0;
	int  hold_reqs = 0, hold_done = 0, hold_left = 0;
	longint cycles = 0;

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void add_grad(int l, int r, int u, int d);
		longint dx = r - l;
		longint dy = u - d;
		longint unsigned mag = floor_sqrt(dx * dx + dy * dy);
		if ({16'd0, tv_total} + mag >= {16'd0, TOTAL_MAX}) begin
			tv_total = TOTAL_MAX;
			tv_sat = 1'b1;
		end else begin
			tv_total = TOTAL_W'(tv_total + mag);
		end
	endfunction

	function automatic void restart_frame();
		col_pos = 0; row_pos = 0; tv_total = '0; tv_sat = 1'b0;
		win_left = 0; win_mid = 0; win_right = 0;
	endfunction

	function automatic int eff_dim(logic [10:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// one pixel into the shadow; returns 1 when the frame closes
	function automatic bit tv_pixel(logic [15:0] px, output frame_sum_t fs);
		int w = eff_dim(width_reg, MAXW);
		int h = eff_dim(height_reg, MAXH);
		int c = col_pos, r = row_pos;
		int p = $signed(px);
		int m, u, l, rt;
		fs = '{default: '0};
		if (c >= w) c = w - 1;
		if (r >= h) r = h - 1;
		if (r > 0) begin
			m = $signed(prev_row[c]);
			win_left = (c > 0) ? win_mid : m;
			win_mid = m;
			win_right = (c + 1 < w) ? $signed(prev_row[c+1]) : m;
			u = (r > 1) ? $signed(older_row[c]) : m;
			add_grad(win_left, win_right, u, p);
		end
		older_row[c] = prev_row[c];
		prev_row[c] = px;
		if (c + 1 < w) begin
			col_pos = c + 1;
			return 0;
		end
		col_pos = 0;
		if (r + 1 < h) begin
			row_pos = r + 1;
			return 0;
		end
		// flush of the last row: lower neighbour is the pixel itself
		for (int k = 0; k < w; k++) begin
			m = $signed(prev_row[k]);
			l = (k > 0) ? $signed(prev_row[k-1]) : m;
			rt = (k + 1 < w) ? $signed(prev_row[k+1]) : m;
			u = (h > 1) ? $signed(older_row[k]) : m;
			add_grad(l, rt, u, m);
		end
		fs.total = tv_total;
		fs.sat = tv_sat;
		restart_frame();
		return 1;
	endfunction

	function automatic int send_idle_pct();
		return (idle_mode == 0) ? 19 : (idle_mode == 1) ? 59 : 0;
	endfunction

	function automatic int recv_idle_pct();
		return (idle_mode == 0) ? 59 : (idle_mode == 1) ? 19 : 0;
	endfunction

	task automatic send_pixel(logic [15:0] px, bit typed = 0, logic [47:0] typed_total = '0);
		frame_sum_t fs;
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct()) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct());
		end
		s_tdata <= px;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		if (tv_pixel(px, fs)) begin
			if (typed) fs.total = typed_total;
			sum_q.push_back(fs);
			frames_done++;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sum_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic reg_write(logic idx, logic [31:0] val);
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (idx == REG_FRAME_WIDTH) width_reg = val[10:0];
		else height_reg = val[10:0];
		restart_frame();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
		if (rd[10:0] != val[10:0]) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register %0d readback: expected %h got %h", idx, val[10:0], rd[10:0]);
		end
	endtask

	task automatic set_frame(logic [31:0] w, logic [31:0] h);
		wait_idle();
		reg_write(REG_FRAME_WIDTH, w | ($urandom() & 32'hFFFF_F800));
		reg_write(REG_FRAME_HEIGHT, h | ($urandom() & 32'hFFFF_F800));
	endtask

	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(255)) - 16'd128;
			default: return 16'($urandom());
		endcase
	endfunction

	// results side
	always @(negedge clk) begin
		if (hold_reqs > hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= 3000;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct());
		end
	end

	always @(posedge clk) begin
		frame_sum_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (sum_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
			end else begin
				want = sum_q.pop_front();
				if (m_tdata[47:0] !== want.total || m_tdata[48] !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected total %h sat %b, got total %h sat %b",
							results_seen, want.total, want.sat, m_tdata[47:0], m_tdata[48]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sum_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	stim_row_t dir_rows [] = '{
		'{ROW_WIDTH, 1, 0, 0}, '{ROW_HEIGHT, 1, 0, 0},
		'{ROW_PIXEL, 16'h1234, 1, 0}, '{ROW_PIXEL, 16'h8000, 1, 0},
		'{ROW_WIDTH, 2, 0, 0},
		'{ROW_PIXEL, 16'h7FFF, 0, 0}, '{ROW_PIXEL, 16'h8000, 1, 131070},
		'{ROW_WIDTH, 0, 0, 0}, '{ROW_HEIGHT, 0, 0, 0},
		'{ROW_PIXEL, 16'h7FFF, 1, 0},
		'{ROW_WIDTH, 1, 0, 0}, '{ROW_HEIGHT, 2, 0, 0},
		'{ROW_PIXEL, 16'h7FFF, 0, 0}, '{ROW_PIXEL, 16'h8000, 1, 131070},
		'{ROW_WIDTH, 3, 0, 0}, '{ROW_HEIGHT, 3, 0, 0},
		'{ROW_PIXEL, 16'h7FFF, 0, 0}, '{ROW_PIXEL, 16'h8000, 0, 0},
		'{ROW_PIXEL, 16'h0000, 0, 0}, '{ROW_PIXEL, 16'h8000, 0, 0},
		'{ROW_PIXEL, 16'h7FFF, 0, 0}, '{ROW_PIXEL, 16'hFFFF, 0, 0},
		'{ROW_PIXEL, 16'h0001, 0, 0}, '{ROW_PIXEL, 16'h7FFF, 0, 0},
		'{ROW_PIXEL, 16'h8000, 0, 0}
	};

	initial begin
		int w, h, n, frames;
		restart_frame();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_WIDTH: begin
					wait_idle();
					reg_write(REG_FRAME_WIDTH, dir_rows[i].value);
				end
				ROW_HEIGHT: begin
					wait_idle();
					reg_write(REG_FRAME_HEIGHT, dir_rows[i].value);
				end
				default: send_pixel(dir_rows[i].value[15:0], dir_rows[i].typed, dir_rows[i].total);
			endcase
		end

		// widest frame, width register value above the maximum
		set_frame(2047, 1);
		repeat (MAXW) send_pixel(rand_pixel());
		// height above the maximum, frame cut short by the next write
		set_frame(1, 2047);
		repeat (48) send_pixel(rand_pixel());

		// output held off while single-pixel frames keep coming
		set_frame(1, 1);
		hold_reqs++;
		repeat (40) send_pixel(rand_pixel());

		n = 0;
		while (n < ITEM_GOAL) begin
			idle_mode = (n < ITEM_GOAL / 3) ? 0 : (n < 2 * ITEM_GOAL / 3) ? 1 : 2;
			case ($urandom_range(9))
				0: begin w = 0; h = $urandom_range(3); end
				1: begin w = $urandom_range(40, 1); h = $urandom_range(3, 1); end
				default: begin w = $urandom_range(8, 1); h = $urandom_range(6, 1); end
			endcase
			set_frame(w, h);
			frames = $urandom_range(3, 1);
			repeat (frames) begin
				repeat (eff_dim(11'(w), MAXW) * eff_dim(11'(h), MAXH)) begin
					send_pixel(rand_pixel());
					n++;
				end
			end
			// an unfinished frame, cut short by the next register write
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(eff_dim(11'(w), MAXW) * eff_dim(11'(h), MAXH) - 1)) begin
					send_pixel(rand_pixel());
					n++;
				end
			end
		end

		wait_idle();
		$display("%0d pixels in %0d frames, %0d result words checked, sizes 1x1 to 1024 wide",
			pixels_sent, frames_done, results_seen);
		$display("register clamping, mid-frame restarts and a long output stall were exercised");
		if (mismatches == 0 && sum_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* total_variation_accumulator_unit.f */
design/tva_pkg.sv
design/tva_ram.sv
design/tva_sqrt.sv
design/total_variation_accumulator_unit.sv
dv/tb_total_variation_accumulator_unit.sv
